FILE: sv/tbdr_pkg.sv
package tbdr_pkg;

  localparam int unsigned TIME_W     = 48;
  localparam int unsigned DEB_W      = 4;
  localparam int unsigned DELAY_W    = 24;
  localparam int unsigned HOLD_W     = 26;
  localparam int unsigned CFG_DATA_W = 32;
  localparam int unsigned CFG_ADDR_W = 4;

  localparam logic [DEB_W-1:0]   DEBOUNCE_COUNT_RST  = DEB_W'(2);
  localparam logic [DELAY_W-1:0] REPEAT_DELAY_RST    = DELAY_W'(450000);
  localparam logic [DELAY_W-1:0] REPEAT_INTERVAL_RST = DELAY_W'(200000);
  localparam logic [HOLD_W-1:0]  POWEROFF_HOLD_RST   = HOLD_W'(2500000);

  typedef enum logic [1:0] {
    REG_DEBOUNCE_COUNT  = 2'd0,
    REG_REPEAT_DELAY    = 2'd1,
    REG_REPEAT_INTERVAL = 2'd2,
    REG_POWEROFF_HOLD   = 2'd3
  } reg_idx_t;

  typedef struct packed {
    logic [DEB_W-1:0]   debounce_count;
    logic [DELAY_W-1:0] repeat_delay_us;
    logic [DELAY_W-1:0] repeat_interval_us;
    logic [HOLD_W-1:0]  poweroff_hold_us;
  } cfg_t;

  typedef struct packed {
    logic up_event;
    logic down_event;
    logic power_off;
  } res_t;

  // press: a new press is accepted this poll; held: stable pressed, no mismatch
  typedef struct packed {
    logic press;
    logic held;
  } deb_status_t;

  // Elapsed time since then reaches thresh; a timestamp before then counts as zero.
  function automatic logic time_reached(input logic [TIME_W-1:0] now,
                                        input logic [TIME_W-1:0] then,
                                        input logic [HOLD_W-1:0] thresh);
    logic [TIME_W:0]   diff;
    logic [TIME_W-1:0] el;
    diff = {1'b0, now} - {1'b0, then};
    el   = diff[TIME_W] ? '0 : diff[TIME_W-1:0];
    return el >= {{(TIME_W - HOLD_W){1'b0}}, thresh};
  endfunction

endpackage

FILE: sv/tbdr_ifs.sv
interface tbdr_in_if;
  logic                        valid;
  logic                        ready;
  logic                        up_level;
  logic                        down_level;
  logic [tbdr_pkg::TIME_W-1:0] now_us;

  modport source (output valid, output up_level, output down_level, output now_us,
                  input ready);
  modport sink   (input valid, input up_level, input down_level, input now_us,
                  output ready);
endinterface

interface tbdr_out_if;
  logic valid;
  logic ready;
  logic up_event;
  logic down_event;
  logic power_off;

  modport source (output valid, output up_event, output down_event, output power_off,
                  input ready);
  modport sink   (input valid, input up_event, input down_event, input power_off,
                  output ready);
endinterface

FILE: sv/two_button_debounce_repeat_longpress.sv
// Flow: an accepted transaction is held in the input register, evaluated by the core,
// and its result is captured in the output register once that register is free.
// Throughput: one transaction per cycle while the sink takes each result; the input
// register and output register let a new poll enter while a finished result waits to be taken.
// Reset (rst_n low, synchronous): clears pipeline valids, debounce state and the
// halt flag, and loads the configuration registers with their default values.
module two_button_debounce_repeat_longpress (
  input  logic                             clk,
  input  logic                             rst_n,
  tbdr_in_if.sink                          in_ch,
  tbdr_out_if.source                       out_ch,
  input  logic                             cfg_psel,
  input  logic                             cfg_penable,
  input  logic                             cfg_pwrite,
  input  logic [tbdr_pkg::CFG_ADDR_W-1:0]  cfg_paddr,
  input  logic [tbdr_pkg::CFG_DATA_W-1:0]  cfg_pwdata,
  output logic [tbdr_pkg::CFG_DATA_W-1:0]  cfg_prdata,
  output logic                             cfg_pready
);
  import tbdr_pkg::*;

  cfg_t cfg;

  // Input register: holds one poll until the core evaluates it.
  logic              s1_valid_r;
  logic              s1_up_r, s1_dn_r;
  logic [TIME_W-1:0] s1_now_r;

  // Output register: holds the result until the sink takes it.
  logic out_valid_r;
  res_t out_res_r;
  res_t core_res;

  logic s1_adv;
  logic in_fire;

  tbdr_cfg_regs u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (cfg_psel),
    .penable (cfg_penable),
    .pwrite  (cfg_pwrite),
    .paddr   (cfg_paddr),
    .pwdata  (cfg_pwdata),
    .prdata  (cfg_prdata),
    .pready  (cfg_pready),
    .cfg     (cfg)
  );

  // Advance the held poll into the output register whenever that register is
  // free or being drained this cycle; the core's state commits on the same edge,
  // so the next poll always sees the state its predecessor left.
  assign s1_adv      = s1_valid_r && (!out_valid_r || out_ch.ready);
  assign in_ch.ready = !s1_valid_r || s1_adv;
  assign in_fire     = in_ch.valid && in_ch.ready;

  tbdr_core u_core (
    .clk        (clk),
    .rst_n      (rst_n),
    .en         (s1_adv),
    .up_level   (s1_up_r),
    .down_level (s1_dn_r),
    .now_us     (s1_now_r),
    .cfg        (cfg),
    .res        (core_res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_fire) begin
      s1_valid_r <= 1'b1;
    end else if (s1_adv) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_up_r  <= in_ch.up_level;
      s1_dn_r  <= in_ch.down_level;
      s1_now_r <= in_ch.now_us;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_adv) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      out_res_r <= core_res;
    end
  end

  // Every poll yields exactly one result, all zeros once halted.
  assign out_ch.valid      = out_valid_r;
  assign out_ch.up_event   = out_res_r.up_event;
  assign out_ch.down_event = out_res_r.down_event;
  assign out_ch.power_off  = out_res_r.power_off;

endmodule

FILE: sv/tbdr_debounce.sv
module tbdr_debounce (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         en,
  input  logic                         raw_pressed,
  input  logic [tbdr_pkg::DEB_W-1:0]   debounce_count,
  output tbdr_pkg::deb_status_t        status
);
  import tbdr_pkg::*;

  logic             stable_r, stable_nxt;
  logic [DEB_W-1:0] count_r, count_nxt, count_inc;
  logic             mismatch;
  logic             changed;

  always_comb begin
    count_inc  = count_r + DEB_W'(1);
    mismatch   = raw_pressed != stable_r;
    count_nxt  = '0;
    stable_nxt = stable_r;
    changed    = 1'b0;
    if (mismatch) begin
      if (count_inc < debounce_count) begin
        count_nxt = count_inc;
      end else begin
        stable_nxt = raw_pressed;
        changed    = 1'b1;
      end
    end
  end

  assign status.press = changed && raw_pressed;
  assign status.held  = stable_r && !mismatch;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stable_r <= 1'b0;
      count_r  <= '0;
    end else if (en) begin
      stable_r <= stable_nxt;
      count_r  <= count_nxt;
    end
  end

endmodule

FILE: sv/tbdr_cfg_regs.sv
module tbdr_cfg_regs (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [tbdr_pkg::CFG_ADDR_W-1:0]  paddr,
  input  logic [tbdr_pkg::CFG_DATA_W-1:0]  pwdata,
  output logic [tbdr_pkg::CFG_DATA_W-1:0]  prdata,
  output logic                             pready,
  output tbdr_pkg::cfg_t                   cfg
);
  import tbdr_pkg::*;

  cfg_t     cfg_r;
  reg_idx_t idx;
  logic     wr_en;

  assign idx    = reg_idx_t'(paddr[3:2]);
  assign wr_en  = psel && penable && pwrite;
  assign pready = 1'b1;
  assign cfg    = cfg_r;

  always_comb begin
    case (idx)
      REG_DEBOUNCE_COUNT:  prdata = CFG_DATA_W'(cfg_r.debounce_count);
      REG_REPEAT_DELAY:    prdata = CFG_DATA_W'(cfg_r.repeat_delay_us);
      REG_REPEAT_INTERVAL: prdata = CFG_DATA_W'(cfg_r.repeat_interval_us);
      REG_POWEROFF_HOLD:   prdata = CFG_DATA_W'(cfg_r.poweroff_hold_us);
      default:             prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.debounce_count     <= DEBOUNCE_COUNT_RST;
      cfg_r.repeat_delay_us    <= REPEAT_DELAY_RST;
      cfg_r.repeat_interval_us <= REPEAT_INTERVAL_RST;
      cfg_r.poweroff_hold_us   <= POWEROFF_HOLD_RST;
    end else if (wr_en) begin
      case (idx)
        REG_DEBOUNCE_COUNT:  cfg_r.debounce_count     <= pwdata[DEB_W-1:0];
        REG_REPEAT_DELAY:    cfg_r.repeat_delay_us    <= pwdata[DELAY_W-1:0];
        REG_REPEAT_INTERVAL: cfg_r.repeat_interval_us <= pwdata[DELAY_W-1:0];
        REG_POWEROFF_HOLD:   cfg_r.poweroff_hold_us   <= pwdata[HOLD_W-1:0];
        default:             cfg_r <= cfg_r;
      endcase
    end
  end

endmodule

FILE: sv/tbdr_core.sv
module tbdr_core (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        en,
  input  logic                        up_level,
  input  logic                        down_level,
  input  logic [tbdr_pkg::TIME_W-1:0] now_us,
  input  tbdr_pkg::cfg_t              cfg,
  output tbdr_pkg::res_t              res
);
  import tbdr_pkg::*;

  logic              halted_r;
  logic [TIME_W-1:0] up_press_r, up_last_rep_r, dn_press_r;
  deb_status_t       up_st, dn_st;
  logic              deb_en;
  logic              up_rep, pwr_hit;

  // Freeze the debouncers once halted.
  assign deb_en = en && !halted_r;

  tbdr_debounce u_up_deb (
    .clk            (clk),
    .rst_n          (rst_n),
    .en             (deb_en),
    .raw_pressed    (!up_level),
    .debounce_count (cfg.debounce_count),
    .status         (up_st)
  );

  tbdr_debounce u_dn_deb (
    .clk            (clk),
    .rst_n          (rst_n),
    .en             (deb_en),
    .raw_pressed    (!down_level),
    .debounce_count (cfg.debounce_count),
    .status         (dn_st)
  );

  always_comb begin
    up_rep  = up_st.held &&
              time_reached(now_us, up_press_r, HOLD_W'(cfg.repeat_delay_us)) &&
              time_reached(now_us, up_last_rep_r, HOLD_W'(cfg.repeat_interval_us));
    pwr_hit = dn_st.held && time_reached(now_us, dn_press_r, cfg.poweroff_hold_us);
    res.up_event   = !halted_r && (up_st.press || up_rep);
    res.down_event = !halted_r && dn_st.press;
    res.power_off  = !halted_r && pwr_hit;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      halted_r <= 1'b0;
    end else if (en && res.power_off) begin
      halted_r <= 1'b1;
    end
  end

  // Timestamps are only read after the matching press has written them.
  always_ff @(posedge clk) begin
    if (deb_en) begin
      if (up_st.press) begin
        up_press_r    <= now_us;
        up_last_rep_r <= now_us;
      end else if (up_rep) begin
        up_last_rep_r <= now_us;
      end
      if (dn_st.press) begin
        dn_press_r <= now_us;
      end
    end
  end

  a_halt_after_poweroff: assert property (@(posedge clk) disable iff (!rst_n)
    (en && res.power_off) |=> halted_r)
    else $error("power off did not halt the block");

  a_halt_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    halted_r |=> halted_r && (res == '0))
    else $error("halted state left or produced events");

  a_press_no_poweroff: assert property (@(posedge clk) disable iff (!rst_n)
    (en && res.down_event) |-> !res.power_off)
    else $error("down press and power off on the same poll");

endmodule
